// File: sv/spc_pkg.sv
// Shared constants, types and the arctangent table for the sonar
// polar-to-Cartesian scan converter. No dependencies.

package spc_pkg;

  localparam int THR_W      = 8;
  localparam int RSTEP_W    = 20;
  localparam int HALF_W     = 18;
  localparam int ASTEP_W    = 27;
  localparam int INT_W      = 16;
  localparam int COORD_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // CORDIC datapath widths: x and y in Q1.30 with headroom, angles in Q.24.
  localparam int XY_W   = 33;
  localparam int Z_W    = 28;
  localparam int TRIG_W = 28;

  localparam logic [26:0] TWO_PI_Q24  = 27'd105414358;
  localparam logic [26:0] PI_Q24      = 27'd52707179;
  localparam logic [26:0] HALF_PI_Q24 = 27'd26353589;

  localparam logic [XY_W-1:0] CORDIC_GAIN_Q30 = 33'd652032874;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD  = 3'd0,
    CFG_NORMALIZE  = 3'd1,
    CFG_RANGE_STEP = 3'd2,
    CFG_HALF_ANGLE = 3'd3,
    CFG_ANGLE_STEP = 3'd4
  } cfg_idx_t;

  // atan(2^-i) in Q.24.
  function automatic logic [23:0] atan_q24(input int unsigned idx);
    logic [23:0] v;
    case (idx)
      0:       v = 24'd13176795;
      1:       v = 24'd7778716;
      2:       v = 24'd4110060;
      3:       v = 24'd2086331;
      4:       v = 24'd1047214;
      5:       v = 24'd524117;
      6:       v = 24'd262123;
      7:       v = 24'd131069;
      8:       v = 24'd65536;
      9:       v = 24'd32768;
      10:      v = 24'd16384;
      11:      v = 24'd8192;
      12:      v = 24'd4096;
      13:      v = 24'd2048;
      14:      v = 24'd1024;
      15:      v = 24'd512;
      16:      v = 24'd256;
      17:      v = 24'd128;
      18:      v = 24'd64;
      19:      v = 24'd32;
      20:      v = 24'd16;
      21:      v = 24'd8;
      22:      v = 24'd4;
      23:      v = 24'd2;
      default: v = 24'd0;
    endcase
    return v;
  endfunction

endpackage

// File: sv/spc_mod_cell.sv
// One restoring step of the bearing reduction modulo 2*pi.
// Depends on spc_pkg for the 2*pi constant in Q.24.

module spc_mod_cell
  import spc_pkg::*;
#(
  parameter int W      = 39,
  parameter int SHIFT  = 0,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              valid_i,
  input  logic [W-1:0]      rem_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output logic [W-1:0]      rem_o,
  output logic [SIDE_W-1:0] side_o
);

  localparam logic [W-1:0] SUB = W'(TWO_PI_Q24) << SHIFT;

  logic              valid_r;
  logic [W-1:0]      rem_r;
  logic [SIDE_W-1:0] side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
    rem_r  <= (rem_i >= SUB) ? rem_i - SUB : rem_i;
    side_r <= side_i;
  end

  assign valid_o = valid_r;
  assign rem_o   = rem_r;
  assign side_o  = side_r;

endmodule

// File: sv/spc_cordic_cell.sv
// One rotation of the CORDIC sine/cosine chain, registered.
// Depends on spc_pkg for datapath widths and the arctangent table.

module spc_cordic_cell
  import spc_pkg::*;
#(
  parameter int IDX    = 0,
  parameter int SIDE_W = 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   valid_i,
  input  logic signed [XY_W-1:0] x_i,
  input  logic signed [XY_W-1:0] y_i,
  input  logic signed [Z_W-1:0]  z_i,
  input  logic [SIDE_W-1:0]      side_i,
  output logic                   valid_o,
  output logic signed [XY_W-1:0] x_o,
  output logic signed [XY_W-1:0] y_o,
  output logic signed [Z_W-1:0]  z_o,
  output logic [SIDE_W-1:0]      side_o
);

  localparam logic signed [Z_W-1:0] ATAN = Z_W'(atan_q24(IDX));

  logic                   valid_r;
  logic signed [XY_W-1:0] x_r;
  logic signed [XY_W-1:0] y_r;
  logic signed [Z_W-1:0]  z_r;
  logic [SIDE_W-1:0]      side_r;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
    // A non-negative residual angle rotates counterclockwise.
    if (!z_i[Z_W-1]) begin
      x_r <= x_i - dx;
      y_r <= y_i + dy;
      z_r <= z_i - ATAN;
    end else begin
      x_r <= x_i + dx;
      y_r <= y_i - dy;
      z_r <= z_i + ATAN;
    end
    side_r <= side_i;
  end

  assign valid_o = valid_r;
  assign x_o     = x_r;
  assign y_o     = y_r;
  assign z_o     = z_r;
  assign side_o  = side_r;

endmodule

// File: sv/sonar_polar_to_cartesian_unit.sv
// Top level of the sonar polar-to-Cartesian scan converter.
// Depends on spc_pkg, spc_mod_cell and spc_cordic_cell.
//
// Usage:
//   Input: a pixel beat (range bin, beam column, pixel value) is taken at a
//   rising edge where start is high and busy is low. busy is high only
//   during reset and the cycle after it, so one pixel is taken per clock.
//   Pixels at or below the threshold travel down the pipeline as bubbles
//   and produce no result.
//   Output: out_valid is high for one cycle with x_pos, y_pos and the
//   intensity; the receiver cannot stall it, and the pipeline never stops.
//   The pipeline has COL_BITS + CORDIC_STAGES + 8 register stages, the first
//   loaded by the accepting edge: three input stages, COL_BITS + 1 restoring
//   cells of the modulo-2*pi bearing reduction, a fold stage, one cell per
//   CORDIC rotation, and rounding, multiply and saturation stages.
//   Throughput: one pixel per clock.
//   Config: writes on the cfg_ channel are always taken (cfg_ready high) and
//   are meant for when no pixel is in flight. Unknown indexes are ignored.
//   Reset: synchronous, clears the pipeline and loads the register defaults.

module sonar_polar_to_cartesian_unit
  import spc_pkg::*;
#(
  parameter int ROW_BITS      = 12,
  parameter int COL_BITS      = 12,
  parameter int CORDIC_STAGES = 18
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [ROW_BITS-1:0]       in_range_bin,
  input  logic [COL_BITS-1:0]       in_beam_column,
  input  logic [7:0]                in_pixel_value,
  output logic                      out_valid,
  output logic signed [COORD_W-1:0] out_x_pos,
  output logic signed [COORD_W-1:0] out_y_pos,
  output logic [INT_W-1:0]          out_intensity_out,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  localparam int RANGE_W  = ROW_BITS + RSTEP_W;
  localparam int PROD_W   = COL_BITS + ASTEP_W;
  localparam int NRED     = COL_BITS + 1;
  localparam int MSIDE_W  = INT_W + RANGE_W;
  localparam int CSIDE_W  = MSIDE_W + 1;
  localparam int MUL_W    = RANGE_W + TRIG_W + 1;

  localparam logic signed [Z_W-1:0]   PI_S      = Z_W'(PI_Q24);
  localparam logic signed [Z_W-1:0]   TWO_PI_S  = Z_W'(TWO_PI_Q24);
  localparam logic signed [Z_W-1:0]   HALF_S    = Z_W'(HALF_PI_Q24);
  localparam logic signed [XY_W-1:0]  RND_XY    = XY_W'(32);
  localparam logic signed [MUL_W-1:0] RND_MUL   = MUL_W'(134217728);
  localparam logic signed [MUL_W-1:0] SAT_MAX   = MUL_W'(2147483647);
  localparam logic signed [MUL_W-1:0] SAT_MIN   = ~SAT_MAX;

  // Configuration registers.
  logic [THR_W-1:0]   thr_r;
  logic               norm_r;
  logic [RSTEP_W-1:0] rstep_r;
  logic [HALF_W-1:0]  half_r;
  logic [ASTEP_W-1:0] astep_r;
  logic               busy_r;

  assign cfg_ready = 1'b1;
  assign busy      = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= 8'd1;
      norm_r  <= 1'b1;
      rstep_r <= 20'd15518;
      half_r  <= 18'd68629;
      astep_r <= 27'd43919;
      busy_r  <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD:  thr_r   <= cfg_data[THR_W-1:0];
          CFG_NORMALIZE:  norm_r  <= cfg_data[0];
          CFG_RANGE_STEP: rstep_r <= cfg_data[RSTEP_W-1:0];
          CFG_HALF_ANGLE: half_r  <= cfg_data[HALF_W-1:0];
          CFG_ANGLE_STEP: astep_r <= cfg_data[ASTEP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Stage 1: capture, threshold and intensity.
  logic                accept;
  logic [INT_W-1:0]    inten_nxt;
  logic                v1_r;
  logic [ROW_BITS-1:0] row1_r;
  logic [COL_BITS-1:0] col1_r;
  logic [INT_W-1:0]    inten1_r;

  assign accept = start && !busy_r;

  // pixel*65536 = pixel*255*257 + pixel, so the rounded quotient by 255 is
  // pixel*257 plus one when pixel + 127 reaches 255.
  always_comb begin
    if (!norm_r) begin
      inten_nxt = {8'd0, in_pixel_value};
    end else if (in_pixel_value == 8'hFF) begin
      inten_nxt = 16'hFFFF;
    end else begin
      inten_nxt = {in_pixel_value, in_pixel_value} + 16'(in_pixel_value[7]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else begin
      v1_r <= accept && (in_pixel_value > thr_r);
    end
    row1_r   <= in_range_bin;
    col1_r   <= in_beam_column;
    inten1_r <= inten_nxt;
  end

  // Stage 2: range and raw bearing products.
  logic [RANGE_W-1:0] range_prod;
  logic [PROD_W-1:0]  ang_prod;
  logic [PROD_W:0]    theta_nxt;
  logic               v2_r;
  logic [RANGE_W-1:0] range2_r;
  logic [PROD_W:0]    theta2_r;
  logic [INT_W-1:0]   inten2_r;

  assign range_prod = row1_r * rstep_r;
  assign ang_prod   = col1_r * astep_r;
  assign theta_nxt  = {1'b0, ang_prod} - (PROD_W+1)'({half_r, 8'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else begin
      v2_r <= v1_r;
    end
    range2_r <= range_prod;
    theta2_r <= theta_nxt;
    inten2_r <= inten1_r;
  end

  // Stage 3: a negative bearing is never below -2*pi, so one add of 2*pi
  // makes it non-negative before the restoring chain.
  logic               v3_r;
  logic [PROD_W-1:0]  r3_r;
  logic [MSIDE_W-1:0] side3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else begin
      v3_r <= v2_r;
    end
    r3_r    <= theta2_r[PROD_W] ? theta2_r[PROD_W-1:0] + PROD_W'(TWO_PI_Q24)
                                : theta2_r[PROD_W-1:0];
    side3_r <= {inten2_r, range2_r};
  end

  // Restoring reduction chain, highest multiple of 2*pi first.
  logic               red_v    [0:NRED];
  logic [PROD_W-1:0]  red_rem  [0:NRED];
  logic [MSIDE_W-1:0] red_side [0:NRED];

  assign red_v[0]    = v3_r;
  assign red_rem[0]  = r3_r;
  assign red_side[0] = side3_r;

  for (genvar j = 0; j < NRED; j++) begin : g_red
    spc_mod_cell #(
      .W      (PROD_W),
      .SHIFT  (NRED - 1 - j),
      .SIDE_W (MSIDE_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (red_v[j]),
      .rem_i   (red_rem[j]),
      .side_i  (red_side[j]),
      .valid_o (red_v[j+1]),
      .rem_o   (red_rem[j+1]),
      .side_o  (red_side[j+1])
    );
  end

  // Fold: [0, 2*pi) to [-pi, pi], then into [-pi/2, pi/2] with a sign flip.
  logic signed [Z_W-1:0] r_ext;
  logic signed [Z_W-1:0] r_wrap;
  logic signed [Z_W-1:0] z_nxt;
  logic                  neg_nxt;
  logic                  fold_v_r;
  logic signed [Z_W-1:0] fold_z_r;
  logic [CSIDE_W-1:0]    fold_side_r;

  assign r_ext = $signed({1'b0, red_rem[NRED][26:0]});

  always_comb begin
    r_wrap = (r_ext > PI_S) ? r_ext - TWO_PI_S : r_ext;
    if (r_wrap > HALF_S) begin
      z_nxt   = r_wrap - PI_S;
      neg_nxt = 1'b1;
    end else if (r_wrap < -HALF_S) begin
      z_nxt   = r_wrap + PI_S;
      neg_nxt = 1'b1;
    end else begin
      z_nxt   = r_wrap;
      neg_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_v_r <= 1'b0;
    end else begin
      fold_v_r <= red_v[NRED];
    end
    fold_z_r    <= z_nxt;
    fold_side_r <= {neg_nxt, red_side[NRED]};
  end

  // CORDIC rotation chain.
  logic                   cor_v    [0:CORDIC_STAGES];
  logic signed [XY_W-1:0] cor_x    [0:CORDIC_STAGES];
  logic signed [XY_W-1:0] cor_y    [0:CORDIC_STAGES];
  logic signed [Z_W-1:0]  cor_z    [0:CORDIC_STAGES];
  logic [CSIDE_W-1:0]     cor_side [0:CORDIC_STAGES];

  assign cor_v[0]    = fold_v_r;
  assign cor_x[0]    = CORDIC_GAIN_Q30;
  assign cor_y[0]    = '0;
  assign cor_z[0]    = fold_z_r;
  assign cor_side[0] = fold_side_r;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
    spc_cordic_cell #(
      .IDX    (i),
      .SIDE_W (CSIDE_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (cor_v[i]),
      .x_i     (cor_x[i]),
      .y_i     (cor_y[i]),
      .z_i     (cor_z[i]),
      .side_i  (cor_side[i]),
      .valid_o (cor_v[i+1]),
      .x_o     (cor_x[i+1]),
      .y_o     (cor_y[i+1]),
      .z_o     (cor_z[i+1]),
      .side_o  (cor_side[i+1])
    );
  end

  // Round Q1.30 to Q1.24 and apply the fold sign.
  logic signed [XY_W-1:0]   cos_sh;
  logic signed [XY_W-1:0]   sin_sh;
  logic signed [TRIG_W-1:0] cos_t;
  logic signed [TRIG_W-1:0] sin_t;
  logic                     cor_neg;
  logic                     rnd_v_r;
  logic signed [TRIG_W-1:0] rnd_cos_r;
  logic signed [TRIG_W-1:0] rnd_sin_r;
  logic [RANGE_W-1:0]       rnd_range_r;
  logic [INT_W-1:0]         rnd_inten_r;

  assign cos_sh  = (cor_x[CORDIC_STAGES] + RND_XY) >>> 6;
  assign sin_sh  = (cor_y[CORDIC_STAGES] + RND_XY) >>> 6;
  assign cos_t   = cos_sh[TRIG_W-1:0];
  assign sin_t   = sin_sh[TRIG_W-1:0];
  assign cor_neg = cor_side[CORDIC_STAGES][CSIDE_W-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rnd_v_r <= 1'b0;
    end else begin
      rnd_v_r <= cor_v[CORDIC_STAGES];
    end
    rnd_cos_r   <= cor_neg ? -cos_t : cos_t;
    rnd_sin_r   <= cor_neg ? -sin_t : sin_t;
    rnd_range_r <= cor_side[CORDIC_STAGES][RANGE_W-1:0];
    rnd_inten_r <= cor_side[CORDIC_STAGES][RANGE_W +: INT_W];
  end

  // Range times trig, Q.20 by Q1.24.
  logic                    mul_v_r;
  logic signed [MUL_W-1:0] mul_x_r;
  logic signed [MUL_W-1:0] mul_y_r;
  logic [INT_W-1:0]        mul_inten_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else begin
      mul_v_r <= rnd_v_r;
    end
    mul_x_r     <= $signed({1'b0, rnd_range_r}) * rnd_cos_r;
    mul_y_r     <= $signed({1'b0, rnd_range_r}) * rnd_sin_r;
    mul_inten_r <= rnd_inten_r;
  end

  function automatic logic signed [COORD_W-1:0] scale_sat(
    input logic signed [MUL_W-1:0] p
  );
    logic signed [MUL_W-1:0] s;
    s = (p + RND_MUL) >>> 28;
    if (s > SAT_MAX) begin
      return SAT_MAX[COORD_W-1:0];
    end else if (s < SAT_MIN) begin
      return SAT_MIN[COORD_W-1:0];
    end
    return s[COORD_W-1:0];
  endfunction

  // Output register.
  logic                      out_valid_r;
  logic signed [COORD_W-1:0] out_x_r;
  logic signed [COORD_W-1:0] out_y_r;
  logic [INT_W-1:0]          out_int_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= mul_v_r;
    end
    out_x_r   <= scale_sat(mul_x_r);
    out_y_r   <= scale_sat(mul_y_r);
    out_int_r <= mul_inten_r;
  end

  assign out_valid         = out_valid_r;
  assign out_x_pos         = out_x_r;
  assign out_y_pos         = out_y_r;
  assign out_intensity_out = out_int_r;

  // The restoring chain must leave less than one full turn.
  a_red_bound : assert property (@(posedge clk) disable iff (!rst_n)
    red_v[NRED] |-> (red_rem[NRED] < PROD_W'(TWO_PI_Q24)))
    else $error("bearing reduction left a residue of 2*pi or more");

  // The folded CORDIC angle stays within the convergence range.
  a_fold_range : assert property (@(posedge clk) disable iff (!rst_n)
    fold_v_r |-> (fold_z_r <= HALF_S && fold_z_r >= -HALF_S))
    else $error("folded angle outside [-pi/2, pi/2]");

  // A result beat comes from a beat that passed through the rounding
  // register and then the multiply register.
  a_out_track : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(rnd_v_r, 2))
    else $error("result beat without a matching beat in the tail stages");

endmodule
